[src/stl_pkg.sv]
// Shared types, token kind codes and character helper functions for the source token lexer.
// Used by stl_front, stl_queue and source_token_lexer. Depends on nothing else.
package stl_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_TOKENS = 3;

  localparam logic [4:0] TK_EOF     = 5'd0;
  localparam logic [4:0] TK_ERROR   = 5'd1;
  localparam logic [4:0] TK_IDENT   = 5'd2;
  localparam logic [4:0] TK_NUMBER  = 5'd3;
  localparam logic [4:0] TK_TYPE    = 5'd4;
  localparam logic [4:0] TK_FN      = 5'd5;
  localparam logic [4:0] TK_LPAREN  = 5'd6;
  localparam logic [4:0] TK_RPAREN  = 5'd7;
  localparam logic [4:0] TK_LBRACE  = 5'd8;
  localparam logic [4:0] TK_RBRACE  = 5'd9;
  localparam logic [4:0] TK_LBRACK  = 5'd10;
  localparam logic [4:0] TK_RBRACK  = 5'd11;
  localparam logic [4:0] TK_COMMA   = 5'd12;
  localparam logic [4:0] TK_DOT     = 5'd13;
  localparam logic [4:0] TK_LT      = 5'd14;
  localparam logic [4:0] TK_LE      = 5'd15;
  localparam logic [4:0] TK_GT      = 5'd16;
  localparam logic [4:0] TK_GE      = 5'd17;
  localparam logic [4:0] TK_ASSIGN  = 5'd18;
  localparam logic [4:0] TK_EQ      = 5'd19;
  localparam logic [4:0] TK_BANG    = 5'd20;
  localparam logic [4:0] TK_NE      = 5'd21;
  localparam logic [4:0] TK_PLUS    = 5'd22;
  localparam logic [4:0] TK_MINUS   = 5'd23;
  localparam logic [4:0] TK_ARROW   = 5'd24;
  localparam logic [4:0] TK_STAR    = 5'd25;
  localparam logic [4:0] TK_SLASH   = 5'd26;
  localparam logic [4:0] TK_PERCENT = 5'd27;
  localparam logic [4:0] TK_AMP     = 5'd28;
  localparam logic [4:0] TK_PIPE    = 5'd29;
  localparam logic [4:0] TK_CARET   = 5'd30;

  localparam logic [2:0] KW_NONE = 3'd0;
  localparam logic [2:0] KW_T    = 3'd1;
  localparam logic [2:0] KW_TY   = 3'd2;
  localparam logic [2:0] KW_TYP  = 3'd3;
  localparam logic [2:0] KW_TYPE = 3'd4;
  localparam logic [2:0] KW_F    = 3'd5;
  localparam logic [2:0] KW_FN   = 3'd6;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_LT    = 3'd1;
  localparam logic [2:0] OP_GT    = 3'd2;
  localparam logic [2:0] OP_EQ    = 3'd3;
  localparam logic [2:0] OP_BANG  = 3'd4;
  localparam logic [2:0] OP_MINUS = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_IDENT   = 3'd1,
    MODE_INT     = 3'd2,
    MODE_DOT     = 3'd3,
    MODE_FRAC    = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_OP      = 3'd6
  } mode_t;

  typedef struct packed {
    logic [15:0] column;
    logic [15:0] line;
    logic [15:0] length;
    logic [31:0] offset;
    logic [4:0]  kind;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0]               count;
    token_t [MAX_TOKENS-1:0]  tokens;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) || (c == 8'h5f);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    unique case (c)
      8'h28: return TK_LPAREN;
      8'h29: return TK_RPAREN;
      8'h7b: return TK_LBRACE;
      8'h7d: return TK_RBRACE;
      8'h5b: return TK_LBRACK;
      8'h5d: return TK_RBRACK;
      8'h2c: return TK_COMMA;
      8'h2e: return TK_DOT;
      8'h2b: return TK_PLUS;
      8'h2a: return TK_STAR;
      8'h2f: return TK_SLASH;
      8'h25: return TK_PERCENT;
      8'h26: return TK_AMP;
      8'h7c: return TK_PIPE;
      8'h5e: return TK_CARET;
      default: return TK_EOF;
    endcase
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] c);
    unique case (c)
      8'h3c: return OP_LT;
      8'h3e: return OP_GT;
      8'h3d: return OP_EQ;
      8'h21: return OP_BANG;
      8'h2d: return OP_MINUS;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic logic [4:0] op_one(input logic [2:0] p);
    unique case (p)
      OP_LT: return TK_LT;
      OP_GT: return TK_GT;
      OP_EQ: return TK_ASSIGN;
      OP_BANG: return TK_BANG;
      OP_MINUS: return TK_MINUS;
      default: return TK_ERROR;
    endcase
  endfunction

  function automatic logic [4:0] op_two(input logic [2:0] p);
    unique case (p)
      OP_LT: return TK_LE;
      OP_GT: return TK_GE;
      OP_EQ: return TK_EQ;
      OP_BANG: return TK_NE;
      OP_MINUS: return TK_ARROW;
      default: return TK_ERROR;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [2:0] p);
    unique case (p)
      OP_LT, OP_GT, OP_EQ, OP_BANG: return 8'h3d;
      OP_MINUS: return 8'h3e;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] kw_next(input logic [2:0] p, input logic [7:0] c);
    if (p == KW_T && c == 8'h79) return KW_TY;
    if (p == KW_TY && c == 8'h70) return KW_TYP;
    if (p == KW_TYP && c == 8'h65) return KW_TYPE;
    if (p == KW_F && c == 8'h6e) return KW_FN;
    return KW_NONE;
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

endpackage

[src/source_token_lexer.sv]
// Top level of the source token lexer: stream ports, front end and token queue.
// Depends on stl_pkg, stl_front and stl_queue.
// With an empty queue, an item's first token can be taken in the cycle after its transfer.
// Throughput: one item per cycle while the token queue has three or more free entries;
// otherwise the input stalls, since one item can give up to three tokens.
// Reset (rst, synchronous): empties the queue and restores line and column 1, offset 0, tab 4.
module source_token_lexer #(
  parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // token_kind, token_offset, token_length, start_line,
                                      // start_column, zero fill
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  stl_pkg::push_t push;
  stl_pkg::token_t head;
  logic space, nonempty, s_xfer;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

  assign s_axis_tready = space;
  assign s_xfer = s_axis_tvalid && space;

  stl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_xfer),
    .end_item   (s_axis_tuser),
    .byte_value (s_axis_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push       (push)
  );

  stl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (m_axis_tvalid && m_axis_tready),
    .space    (space),
    .nonempty (nonempty),
    .level    (level),
    .head     (head)
  );

  assign m_axis_tvalid = nonempty;
  assign m_axis_tdata = {3'b000, head.column, head.line, head.length, head.offset, head.kind};
  assign m_axis_tlast = head.last;

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("token queue overflow");
  a_end_gives_token: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> m_axis_tvalid)
    else $error("end item produced no token");
  a_push_has_last: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> push.tokens[push.count - 2'd1].last)
    else $error("token run without last mark");
`endif

endmodule

[src/stl_front.sv]
// Front end of the source token lexer: accepts items, runs the scanner state and
// produces up to three tokens per item. Depends on stl_pkg.
module stl_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 end_item,
  input  logic [7:0]           byte_value,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_wdata,
  output stl_pkg::push_t       push
);

  stl_pkg::mode_t mode, mode_next;
  logic [2:0]  pend, pend_next, kwp, kwp_next;
  logic [31:0] pos, pos_next, tso, tso_next;
  logic [15:0] line, line_next, col, col_next;
  logic [15:0] tsl, tsl_next, tsc, tsc_next, tbc, tbc_next;
  logic [4:0]  tab_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= 5'd4;
      mode <= stl_pkg::MODE_IDLE;
      pend <= stl_pkg::OP_NONE;
      kwp <= stl_pkg::KW_NONE;
      pos <= '0;
      line <= 16'd1;
      col <= 16'd1;
      tso <= '0;
      tsl <= 16'd1;
      tsc <= 16'd1;
      tbc <= '0;
    end else begin
      if (cfg_we) tab_width <= cfg_wdata;
      if (accept) begin
        mode <= mode_next;
        pend <= pend_next;
        kwp <= kwp_next;
        pos <= pos_next;
        line <= line_next;
        col <= col_next;
        tso <= tso_next;
        tsl <= tsl_next;
        tsc <= tsc_next;
        tbc <= tbc_next;
      end
    end
  end

  always_comb begin
    logic [1:0]  n;
    logic        dot_adv, do_start, adv_b;
    logic [31:0] pos_a;
    logic [15:0] col_a;
    logic [4:0]  kw_kind, sk;
    logic [2:0]  oc;
    n = '0;
    dot_adv = 1'b0;
    do_start = 1'b0;
    adv_b = 1'b0;
    push = '0;
    mode_next = mode;
    pend_next = pend;
    kwp_next = kwp;
    tso_next = tso;
    tsl_next = tsl;
    tsc_next = tsc;
    tbc_next = tbc;
    kw_kind = (kwp == stl_pkg::KW_TYPE) ? stl_pkg::TK_TYPE :
              (kwp == stl_pkg::KW_FN) ? stl_pkg::TK_FN : stl_pkg::TK_IDENT;
    sk = stl_pkg::single_kind(byte_value);
    oc = stl_pkg::op_code(byte_value);

    if (end_item) begin
      unique case (mode)
        stl_pkg::MODE_IDENT: begin
          push.tokens[n] = '{tsc, tsl, tbc, tso, kw_kind, 1'b0};
          n = n + 2'd1;
        end
        stl_pkg::MODE_INT, stl_pkg::MODE_FRAC: begin
          push.tokens[n] = '{tsc, tsl, tbc, tso, stl_pkg::TK_NUMBER, 1'b0};
          n = n + 2'd1;
        end
        stl_pkg::MODE_DOT: begin
          push.tokens[n] = '{tsc, tsl, tbc, tso, stl_pkg::TK_NUMBER, 1'b0};
          n = n + 2'd1;
          push.tokens[n] = '{col, line, 16'd1, pos, stl_pkg::TK_DOT, 1'b0};
          n = n + 2'd1;
          dot_adv = 1'b1;
        end
        stl_pkg::MODE_OP: begin
          push.tokens[n] = '{tsc, tsl, tbc, tso, stl_pkg::op_one(pend), 1'b0};
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      mode_next = stl_pkg::MODE_IDLE;
      pend_next = stl_pkg::OP_NONE;
      kwp_next = stl_pkg::KW_NONE;
    end else begin
      unique case (mode)
        stl_pkg::MODE_IDENT: begin
          if (stl_pkg::is_alpha(byte_value) || stl_pkg::is_digit(byte_value)) begin
            tbc_next = stl_pkg::sat16(tbc, 16'd1);
            kwp_next = stl_pkg::kw_next(kwp, byte_value);
            adv_b = 1'b1;
          end else begin
            push.tokens[n] = '{tsc, tsl, tbc, tso, kw_kind, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::MODE_INT, stl_pkg::MODE_FRAC: begin
          if (stl_pkg::is_digit(byte_value)) begin
            tbc_next = stl_pkg::sat16(tbc, 16'd1);
            adv_b = 1'b1;
          end else if (mode == stl_pkg::MODE_INT && byte_value == 8'h2e) begin
            mode_next = stl_pkg::MODE_DOT;
          end else begin
            push.tokens[n] = '{tsc, tsl, tbc, tso, stl_pkg::TK_NUMBER, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::MODE_DOT: begin
          dot_adv = 1'b1;
          if (stl_pkg::is_digit(byte_value)) begin
            tbc_next = stl_pkg::sat16(tbc, 16'd2);
            adv_b = 1'b1;
            mode_next = stl_pkg::MODE_FRAC;
          end else begin
            push.tokens[n] = '{tsc, tsl, tbc, tso, stl_pkg::TK_NUMBER, 1'b0};
            n = n + 2'd1;
            push.tokens[n] = '{col, line, 16'd1, pos, stl_pkg::TK_DOT, 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::MODE_OP: begin
          pend_next = stl_pkg::OP_NONE;
          if (pend != stl_pkg::OP_NONE && byte_value == stl_pkg::op_second(pend)) begin
            tbc_next = 16'd2;
            push.tokens[n] = '{tsc, tsl, 16'd2, tso, stl_pkg::op_two(pend), 1'b0};
            n = n + 2'd1;
            adv_b = 1'b1;
            mode_next = stl_pkg::MODE_IDLE;
          end else begin
            push.tokens[n] = '{tsc, tsl, tbc, tso, stl_pkg::op_one(pend), 1'b0};
            n = n + 2'd1;
            do_start = 1'b1;
          end
        end
        stl_pkg::MODE_COMMENT: begin
          adv_b = 1'b1;
          if (byte_value == 8'h0a) mode_next = stl_pkg::MODE_IDLE;
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    pos_a = (dot_adv && pos != 32'hffffffff) ? pos + 32'd1 : pos;
    col_a = dot_adv ? stl_pkg::sat16(col, 16'd1) : col;

    if (do_start) begin
      adv_b = 1'b1;
      mode_next = stl_pkg::MODE_IDLE;
      if (byte_value == 8'h20 || byte_value == 8'h09 || byte_value == 8'h0a) begin
        mode_next = stl_pkg::MODE_IDLE;
      end else if (byte_value == 8'h23) begin
        mode_next = stl_pkg::MODE_COMMENT;
      end else if (sk != stl_pkg::TK_EOF) begin
        push.tokens[n] = '{col_a, line, 16'd1, pos_a, sk, 1'b0};
        n = n + 2'd1;
      end else if (oc != stl_pkg::OP_NONE || stl_pkg::is_alpha(byte_value) ||
                   stl_pkg::is_digit(byte_value)) begin
        tso_next = pos_a;
        tsl_next = line;
        tsc_next = col_a;
        tbc_next = 16'd1;
        if (oc != stl_pkg::OP_NONE) begin
          pend_next = oc;
          mode_next = stl_pkg::MODE_OP;
        end else if (stl_pkg::is_alpha(byte_value)) begin
          kwp_next = (byte_value == 8'h74) ? stl_pkg::KW_T :
                     (byte_value == 8'h66) ? stl_pkg::KW_F : stl_pkg::KW_NONE;
          mode_next = stl_pkg::MODE_IDENT;
        end else begin
          mode_next = stl_pkg::MODE_INT;
        end
      end else begin
        push.tokens[n] = '{col_a, line, 16'd1, pos_a, stl_pkg::TK_ERROR, 1'b0};
        n = n + 2'd1;
      end
    end

    if (end_item) begin
      push.tokens[n] = '{col_a, line, 16'd0, pos_a, stl_pkg::TK_EOF, 1'b0};
      n = n + 2'd1;
    end

    if (adv_b && !end_item) begin
      pos_next = (pos_a != 32'hffffffff) ? pos_a + 32'd1 : pos_a;
      if (byte_value == 8'h0a) begin
        line_next = stl_pkg::sat16(line, 16'd1);
        col_next = 16'd1;
      end else if (byte_value == 8'h09) begin
        line_next = line;
        col_next = stl_pkg::sat16(col_a, {11'd0, tab_width});
      end else begin
        line_next = line;
        col_next = stl_pkg::sat16(col_a, 16'd1);
      end
    end else begin
      pos_next = pos_a;
      line_next = line;
      col_next = col_a;
    end

    if (n != 2'd0) push.tokens[n - 2'd1].last = 1'b1;
    push.count = accept ? n : 2'd0;
  end

endmodule

[src/stl_queue.sv]
// Token queue and output side of the source token lexer: takes up to three tokens
// a cycle from the front end and hands out one per transfer. Depends on stl_pkg.
module stl_queue #(
  parameter int DEPTH = stl_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  stl_pkg::push_t             push,
  input  logic                       pop,
  output logic                       space,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] level,
  output stl_pkg::token_t            head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  stl_pkg::token_t entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign space = count <= CW'(DEPTH - stl_pkg::MAX_TOKENS);
  assign nonempty = count != '0;
  assign level = count;
  assign head = entries[rd_ptr];

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p, input logic [1:0] k);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(k);
    return (s >= (AW+1)'(DEPTH)) ? AW'(s - (AW+1)'(DEPTH)) : s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    for (int i = 0; i < stl_pkg::MAX_TOKENS; i++) begin
      if (2'(i) < push.count) entries[wrap(wr_ptr, 2'(i))] <= push.tokens[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wrap(wr_ptr, push.count);
      rd_ptr <= wrap(rd_ptr, {1'b0, pop});
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

endmodule
